>>> hw/rtl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

	// Fixed field and register widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 4;
	localparam int CFG_W  = 64;
	localparam int ADDR_W = 5;

	// Configuration register map, one 64-bit register every 8 bytes
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES     = 2'd0,
		REG_PATTERN_LENGTH    = 2'd1,
		REG_SUBSTITUTE_BYTES  = 2'd2,
		REG_SUBSTITUTE_LENGTH = 2'd3
	} reg_idx_t;

	// What one accepted input beat asks the emitter to send, in this order:
	// substitute, single byte, substitute again, then the flushed window
	typedef struct packed {
		logic sub_a;
		logic byte_v;
		logic sub_b;
		logic fin;
	} plan_flags_t;

endpackage

>>> hw/rtl/sfr_ifs.sv
// Valid/ready stream interfaces for source text and rewritten text.
interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       final_byte;

	modport source(output valid, in_byte, final_byte, input ready);
	modport sink(input valid, in_byte, final_byte, output ready);
endinterface

interface sfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;

	modport source(output valid, out_byte, run_end, string_end, input ready);
	modport sink(input valid, out_byte, run_end, string_end, output ready);
endinterface

>>> hw/rtl/sfr_cell.sv
// One window cell: holds a pending byte, compares it to its pattern byte.
module sfr_cell (
	input  logic       clk,
	input  logic       step,
	input  logic       ins,
	input  logic       shift,
	input  logic [7:0] in_byte,
	input  logic [7:0] nbr,
	input  logic [7:0] pat,
	output logic [7:0] cur,
	output logic [7:0] nxt,
	output logic       eq
);
	import sfr_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	// Window content after the new byte is appended
	assign cur = ins ? in_byte : byte_q;
	assign eq  = (cur == pat);
	// Content after a mismatch drops the oldest byte
	assign nxt = shift ? nbr : cur;

	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= nxt;
		end
	end

endmodule

>>> hw/rtl/sfr_window.sv
// Pending-byte window: a row of cells plus the match and flush decision.
module sfr_window #(
	parameter int MAX_PATTERN = 8,
	parameter int PW          = $clog2(MAX_PATTERN + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  logic                             step,
	input  logic [7:0]                       in_byte,
	input  logic                             final_byte,
	input  logic [sfr_pkg::CFG_W-1:0]        pattern_bytes,
	input  logic [PW-1:0]                    plen,
	output sfr_pkg::plan_flags_t             flags,
	output logic [7:0]                       byte_val,
	output logic [MAX_PATTERN-1:0][7:0]      flush,
	output logic [PW-1:0]                    fcnt
);
	import sfr_pkg::*;

	logic [PW-1:0]                   count_q;
	logic [PW-1:0]                   cnt1;
	logic [PW-1:0]                   cnt2;
	logic [MAX_PATTERN-1:0][7:0]     cur;
	logic [MAX_PATTERN-1:0][7:0]     nxt;
	logic [MAX_PATTERN-1:0]          eq;
	logic                            pmode;
	logic                            full;
	logic                            match;
	logic                            shift;
	logic                            eq_all;

	assign pmode = (plen != '0);
	assign cnt1  = count_q + PW'(1);
	assign full  = (cnt1 == plen);

	// Row of cells, each takes its right neighbor's byte on a shift
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [7:0] nbr;
		if (i < MAX_PATTERN - 1) begin : g_mid
			assign nbr = cur[i+1];
		end else begin : g_end
			assign nbr = '0;
		end
		sfr_cell u_cell (
			.clk     (clk),
			.step    (step && pmode),
			.ins     (count_q == PW'(i)),
			.shift   (shift),
			.in_byte (in_byte),
			.nbr     (nbr),
			.pat     (pattern_bytes[8*i +: 8]),
			.cur     (cur[i]),
			.nxt     (nxt[i]),
			.eq      (eq[i])
		);
	end

	// Only the first plen cells take part in the compare
	always_comb begin
		eq_all = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (PW'(i) < plen && !eq[i]) begin
				eq_all = 1'b0;
			end
		end
	end

	assign match = full && eq_all;
	assign shift = full && !eq_all;
	assign cnt2  = match ? '0 : (shift ? count_q : cnt1);

	// Output plan for this beat
	always_comb begin
		flags.fin = final_byte;
		flush     = nxt;
		if (pmode) begin
			flags.sub_a  = match;
			flags.byte_v = shift;
			flags.sub_b  = 1'b0;
			byte_val     = cur[0];
			fcnt         = final_byte ? cnt2 : '0;
		end else begin
			flags.sub_a  = 1'b1;
			flags.byte_v = 1'b1;
			flags.sub_b  = final_byte;
			byte_val     = in_byte;
			fcnt         = '0;
		end
	end

	// Fill level; a pattern rewrite or the last byte empties the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= (pmode && !final_byte) ? cnt2 : '0;
		end
	end

	// Window never holds a whole pattern between beats
	a_count_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < PW'(MAX_PATTERN))
		else $error("window fill reached pattern capacity");

	// Last byte of a string leaves the window empty
	a_fin_empties: assert property (@(posedge clk) disable iff (!arst_n)
		step && final_byte |=> count_q == '0)
		else $error("window not empty after final byte");

	// Insert mode keeps nothing pending
	a_insert_mode_empty: assert property (@(posedge clk) disable iff (!arst_n)
		step && !pmode |=> count_q == '0)
		else $error("window filled in insert mode");

endmodule

>>> hw/rtl/sfr_emit.sv
// Result emitter: walks one beat's plan and drives the output register.
module sfr_emit #(
	parameter int MAX_PATTERN    = 8,
	parameter int MAX_SUBSTITUTE = 8,
	parameter int PW             = $clog2(MAX_PATTERN + 1),
	parameter int SW             = $clog2(MAX_SUBSTITUTE + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  sfr_pkg::plan_flags_t             flags,
	input  logic [7:0]                       byte_val,
	input  logic [MAX_PATTERN-1:0][7:0]      flush,
	input  logic [PW-1:0]                    fcnt,
	input  logic [sfr_pkg::CFG_W-1:0]        subst_bytes,
	input  logic [SW-1:0]                    slen,
	output logic                             can_load,
	sfr_out_if.source                        res
);
	import sfr_pkg::*;

	localparam int SIW = (MAX_SUBSTITUTE > 1) ? $clog2(MAX_SUBSTITUTE) : 1;

	// Job state
	logic                            job_v_q;
	logic                            sub_a_q;
	logic                            byte_v_q;
	logic                            sub_b_q;
	logic                            fin_q;
	logic [7:0]                      byte_q;
	logic [SIW-1:0]                  sidx_q;
	logic [MAX_PATTERN-1:0][7:0]     fl_q;
	logic [PW-1:0]                   fcnt_q;
	// Output register
	logic                            out_v_q;
	logic [7:0]                      out_byte_q;
	logic                            run_end_q;
	logic                            string_end_q;

	logic                            out_free;
	logic                            emit;
	logic                            sub_last;
	logic [7:0]                      sub_byte;
	logic [7:0]                      e_byte;
	logic                            sub_a_n;
	logic                            byte_v_n;
	logic                            sub_b_n;
	logic [SIW-1:0]                  sidx_n;
	logic [MAX_PATTERN-1:0][7:0]     fl_n;
	logic [PW-1:0]                   fcnt_n;
	logic                            last;
	logic                            l_sub_a;
	logic                            l_sub_b;
	logic                            has_work;

	assign out_free = !out_v_q || res.ready;
	assign emit     = job_v_q && out_free;
	assign sub_last = ((SW'(sidx_q) + SW'(1)) == slen);
	assign sub_byte = subst_bytes[{sidx_q, 3'b000} +: 8];

	// Pick the next result beat of the job
	always_comb begin
		e_byte   = fl_q[0];
		sub_a_n  = sub_a_q;
		byte_v_n = byte_v_q;
		sub_b_n  = sub_b_q;
		sidx_n   = sidx_q;
		fl_n     = fl_q;
		fcnt_n   = fcnt_q;
		if (sub_a_q) begin
			e_byte  = sub_byte;
			sub_a_n = !sub_last;
			sidx_n  = sub_last ? '0 : sidx_q + SIW'(1);
		end else if (byte_v_q) begin
			e_byte   = byte_q;
			byte_v_n = 1'b0;
		end else if (sub_b_q) begin
			e_byte  = sub_byte;
			sub_b_n = !sub_last;
			sidx_n  = sub_last ? '0 : sidx_q + SIW'(1);
		end else begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				fl_n[i] = fl_q[i+1];
			end
			fl_n[MAX_PATTERN-1] = '0;
			fcnt_n = fcnt_q - PW'(1);
		end
	end

	assign last     = !(sub_a_n || byte_v_n || sub_b_n || (fcnt_n != '0));
	assign can_load = !job_v_q || (emit && last);

	// An empty substitute contributes no beats
	assign l_sub_a  = flags.sub_a && (slen != '0);
	assign l_sub_b  = flags.sub_b && (slen != '0);
	assign has_work = l_sub_a || flags.byte_v || l_sub_b || (fcnt != '0);

	// Job and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q  <= 1'b0;
			sub_a_q  <= 1'b0;
			byte_v_q <= 1'b0;
			sub_b_q  <= 1'b0;
			sidx_q   <= '0;
			fcnt_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (load) begin
				job_v_q  <= has_work;
				sub_a_q  <= l_sub_a;
				byte_v_q <= flags.byte_v;
				sub_b_q  <= l_sub_b;
				sidx_q   <= '0;
				fcnt_q   <= fcnt;
			end else if (emit) begin
				job_v_q  <= !last;
				sub_a_q  <= sub_a_n;
				byte_v_q <= byte_v_n;
				sub_b_q  <= sub_b_n;
				sidx_q   <= sidx_n;
				fcnt_q   <= fcnt_n;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Job and output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_val;
			fl_q   <= flush;
			fin_q  <= flags.fin;
		end else if (emit) begin
			fl_q <= fl_n;
		end
		if (emit) begin
			out_byte_q   <= e_byte;
			run_end_q    <= last;
			string_end_q <= last && fin_q;
		end
	end

	assign res.valid      = out_v_q;
	assign res.out_byte   = out_byte_q;
	assign res.run_end    = run_end_q;
	assign res.string_end = string_end_q;

	// Substitute index rests at zero between substitute runs
	a_sidx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!sub_a_q && !sub_b_q |-> sidx_q == '0)
		else $error("substitute index left mid-run");

	// An emitted beat always lands in the output register
	a_emit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_v_q)
		else $error("emitted beat lost");

	// string_end only ever closes a run
	a_end_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && string_end_q |-> run_end_q)
		else $error("string end without run end");

endmodule

>>> hw/rtl/stream_find_replace.sv
// Stream find-and-replace top level: APB registers, window and emitter.
// The first result beat of an input passes through the job state, then the output register.
// Throughput: one input beat per cycle while each beat yields at most one result and the
// output is ready; a beat with several results holds the input until its last is emitted.
// The output register lets the next input be taken while a result waits.
// Reset (arst_n low, asynchronous): window empty, no job, registers all zero.
module stream_find_replace #(
	parameter int MAX_PATTERN    = 8,
	parameter int MAX_SUBSTITUTE = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0]    paddr,
	input  logic [sfr_pkg::CFG_W-1:0]     pwdata,
	output logic [sfr_pkg::CFG_W-1:0]     prdata,
	output logic                          pready,
	sfr_in_if.sink                        text,
	sfr_out_if.source                     rewritten
);
	import sfr_pkg::*;

	localparam int PW = $clog2(MAX_PATTERN + 1);
	localparam int SW = $clog2(MAX_SUBSTITUTE + 1);

	logic [CFG_W-1:0]            pat_q;
	logic [LEN_W-1:0]            plen_q;
	logic [CFG_W-1:0]            sub_q;
	logic [LEN_W-1:0]            slen_q;
	reg_idx_t                    idx;
	logic                        wr;
	logic                        clear;
	logic [PW-1:0]               plen_eff;
	logic [SW-1:0]               slen_eff;
	logic                        accept;
	logic                        can_load;
	plan_flags_t                 flags;
	logic [7:0]                  byte_val;
	logic [MAX_PATTERN-1:0][7:0] flush;
	logic [PW-1:0]               fcnt;

	// Register port
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:3]);
	assign wr     = psel && penable && pwrite;
	assign clear  = wr && (idx == REG_PATTERN_BYTES || idx == REG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= '0;
			sub_q  <= '0;
			slen_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_PATTERN_BYTES:     pat_q  <= pwdata;
				REG_PATTERN_LENGTH:    plen_q <= pwdata[LEN_W-1:0];
				REG_SUBSTITUTE_BYTES:  sub_q  <= pwdata;
				REG_SUBSTITUTE_LENGTH: slen_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (idx)
			REG_PATTERN_BYTES:     prdata = pat_q;
			REG_PATTERN_LENGTH:    prdata = CFG_W'(plen_q);
			REG_SUBSTITUTE_BYTES:  prdata = sub_q;
			REG_SUBSTITUTE_LENGTH: prdata = CFG_W'(slen_q);
			default:               prdata = '0;
		endcase
	end

	// Oversized lengths saturate
	assign plen_eff = (plen_q > LEN_W'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : PW'(plen_q);
	assign slen_eff = (slen_q > LEN_W'(MAX_SUBSTITUTE)) ? SW'(MAX_SUBSTITUTE) : SW'(slen_q);

	// Input handshake
	assign text.ready = can_load;
	assign accept     = text.valid && can_load;

	sfr_window #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.clear         (clear),
		.step          (accept),
		.in_byte       (text.in_byte),
		.final_byte    (text.final_byte),
		.pattern_bytes (pat_q),
		.plen          (plen_eff),
		.flags         (flags),
		.byte_val      (byte_val),
		.flush         (flush),
		.fcnt          (fcnt)
	);

	sfr_emit #(
		.MAX_PATTERN    (MAX_PATTERN),
		.MAX_SUBSTITUTE (MAX_SUBSTITUTE)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.flags       (flags),
		.byte_val    (byte_val),
		.flush       (flush),
		.fcnt        (fcnt),
		.subst_bytes (sub_q),
		.slen        (slen_eff),
		.can_load    (can_load),
		.res         (rewritten)
	);

endmodule

>>> tb/tb_stream_find_replace.sv
// Testbench for the stream find-and-replace block: predictor, drivers and stimulus.

// One beat of rewritten text as it leaves the block
typedef struct packed {
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;
} text_beat_t;

// Mirrors the rewrite rule and the held window, predicts rewritten beats
class rewrite_tracker;
	logic [63:0] pat_bytes;
	logic [3:0]  pat_len;
	logic [63:0] sub_bytes;
	logic [3:0]  sub_len;
	logic [7:0]  window [8];
	int unsigned held;
	text_beat_t  burst[$];
	text_beat_t  expected_text[$];
	int unsigned errors;
	int unsigned beats_checked;
	int unsigned hits;
	int unsigned strings_seen;

	function new();
		pat_bytes = '0;
		pat_len = '0;
		sub_bytes = '0;
		sub_len = '0;
		held = 0;
		errors = 0;
		beats_checked = 0;
		hits = 0;
		strings_seen = 0;
	endfunction

	// Lengths above eight saturate
	function int unsigned pattern_span();
		return (pat_len > 4'd8) ? 8 : pat_len;
	endfunction

	function int unsigned substitute_span();
		return (sub_len > 4'd8) ? 8 : sub_len;
	endfunction

	// Any pattern write throws away held bytes and restarts the string
	function void apply_register(sfr_pkg::reg_idx_t idx, logic [63:0] value);
		case (idx)
			sfr_pkg::REG_PATTERN_BYTES: begin
				pat_bytes = value;
				held = 0;
			end
			sfr_pkg::REG_PATTERN_LENGTH: begin
				pat_len = value[3:0];
				held = 0;
			end
			sfr_pkg::REG_SUBSTITUTE_BYTES: sub_bytes = value;
			sfr_pkg::REG_SUBSTITUTE_LENGTH: sub_len = value[3:0];
			default: ;
		endcase
	endfunction

	function void emit(logic [7:0] b);
		text_beat_t beat;
		beat.out_byte = b;
		beat.run_end = 1'b0;
		beat.string_end = 1'b0;
		burst.push_back(beat);
	endfunction

	function void emit_substitute();
		for (int i = 0; i < substitute_span(); i++)
			emit(sub_bytes[8*i +: 8]);
	endfunction

	function void drop_front(int unsigned k);
		for (int i = 0; i + k < held; i++)
			window[i] = window[i + k];
		held -= k;
	endfunction

	// Predict the beats caused by one accepted source byte
	function void take_source_byte(logic [7:0] b, logic fin);
		int unsigned span;
		bit hit;
		span = pattern_span();
		burst.delete();
		if (span == 0) begin
			// insert mode: substitute before every byte and after the last
			emit_substitute();
			emit(b);
			if (fin)
				emit_substitute();
			held = 0;
		end else begin
			window[held] = b;
			held++;
			if (held >= span) begin
				hit = 1'b1;
				for (int i = 0; i < span; i++)
					if (window[i] != pat_bytes[8*i +: 8])
						hit = 1'b0;
				if (hit) begin
					emit_substitute();
					drop_front(span);
					hits++;
				end else begin
					emit(window[0]);
					drop_front(1);
				end
			end
			// flush what is left of the window on the last byte
			if (fin) begin
				for (int i = 0; i < held; i++)
					emit(window[i]);
				held = 0;
			end
		end
		if (fin)
			strings_seen++;
		if (burst.size() > 0) begin
			burst[burst.size() - 1].run_end = 1'b1;
			burst[burst.size() - 1].string_end = fin;
		end
		foreach (burst[i])
			expected_text.push_back(burst[i]);
	endfunction

	// Compare one accepted output beat with the oldest prediction
	function void check_rewritten_byte(text_beat_t got);
		text_beat_t want;
		if (expected_text.size() == 0) begin
			$error("out_byte: expected no beat, actual %02h", got.out_byte);
			errors++;
			return;
		end
		want = expected_text.pop_front();
		beats_checked++;
		if (got.out_byte !== want.out_byte) begin
			$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
			errors++;
		end
		if (got.run_end !== want.run_end) begin
			$error("run_end: expected %b, actual %b", want.run_end, got.run_end);
			errors++;
		end
		if (got.string_end !== want.string_end) begin
			$error("string_end: expected %b, actual %b", want.string_end, got.string_end);
			errors++;
		end
	endfunction
endclass

module tb_stream_find_replace;
	timeunit 1ns;
	timeprecision 1ps;
	import sfr_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int DRAIN_SLACK = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_BYTES = 38;
	localparam logic [3:0] PAT_LENGTHS [PHASES] = '{
		4'd1, 4'd8, 4'd0, 4'd2, 4'd3, 4'd15, 4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd6
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	sfr_in_if  text_if();
	sfr_out_if rewritten_if();

	rewrite_tracker tracker;
	bit             sender_idles;
	bit             receiver_idles;
	int unsigned    stall_left = 0;
	int unsigned    quiet_cycles = 0;
	int unsigned    bytes_sent = 0;
	int unsigned    settings_used = 0;

	stream_find_replace i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.text      (text_if),
		.rewritten (rewritten_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check accepted output beats, then pick next ready with random stall bursts
	always @(posedge clk) begin
		if (arst_n && rewritten_if.valid && rewritten_if.ready)
			tracker.check_rewritten_byte({rewritten_if.out_byte, rewritten_if.run_end,
				rewritten_if.string_end});
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rewritten_if.ready <= 1'b0;
		end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 14);
			rewritten_if.ready <= 1'b0;
		end else begin
			rewritten_if.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((text_if.valid && text_if.ready) || (rewritten_if.valid && rewritten_if.ready)
				|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("tb_stream_find_replace: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one source byte, optionally after an idle burst, and wait for it to go
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			text_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.in_byte <= b;
		text_if.final_byte <= fin;
		do @(posedge clk); while (!text_if.ready);
		tracker.take_source_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_string(input byte_q_t s);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	// Hold the source until every predicted beat is out, then let the pipe settle
	task automatic drain();
		text_if.valid <= 1'b0;
		while (tracker.expected_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.apply_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_rewrite_rule(input logic [63:0] pat, input logic [3:0] plen,
			input logic [63:0] sub, input logic [3:0] slen);
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_PATTERN_LENGTH, CFG_W'(plen));
		write_reg(REG_SUBSTITUTE_BYTES, sub);
		write_reg(REG_SUBSTITUTE_LENGTH, CFG_W'(slen));
		settings_used++;
	endtask

	// Mostly whole or partial pattern copies and pattern bytes, some noise
	function automatic byte_q_t random_string(int unsigned len);
		byte_q_t s;
		int unsigned span;
		int unsigned cut;
		span = tracker.pattern_span();
		while (s.size() < len) begin
			if (span == 0) begin
				s.push_back(8'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						for (int i = 0; i < span; i++)
							s.push_back(tracker.pat_bytes[8*i +: 8]);
					end
					4: begin
						cut = $urandom_range(1, span);
						for (int i = 0; i < cut; i++)
							s.push_back(tracker.pat_bytes[8*i +: 8]);
					end
					5, 6, 7: s.push_back(tracker.pat_bytes[8*$urandom_range(0, span - 1) +: 8]);
					default: s.push_back(8'($urandom));
				endcase
			end
		end
		while (s.size() > len)
			void'(s.pop_back());
		return s;
	endfunction

	// One setting, random strings, a pause halfway with an optional substitute change
	task automatic run_phase(input int unsigned count, input logic [63:0] pat,
			input logic [3:0] plen, input logic [63:0] sub, input logic [3:0] slen);
		byte_q_t s;
		int unsigned left;
		bit paused;
		drain();
		load_rewrite_rule(pat, plen, sub, slen);
		left = count;
		paused = 1'b0;
		while (left > 0) begin
			s = random_string($urandom_range(1, (left < 24) ? left : 24));
			send_string(s);
			left -= s.size();
			if (!paused && left < count / 2) begin
				paused = 1'b1;
				drain();
				if ($urandom_range(0, 1))
					write_reg(REG_SUBSTITUTE_BYTES, {$urandom(), $urandom()});
			end
		end
	endtask

	initial begin
		logic [63:0] pat;
		tracker = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		text_if.valid <= 1'b0;
		text_if.in_byte <= 8'h00;
		text_if.final_byte <= 1'b0;
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset rule: insert mode with empty substitute passes bytes through
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// Insert mode with oversized substitute length: one byte gives 17 beats
		drain();
		load_rewrite_rule(64'h0, 4'd0, 64'h8899_AABB_CCDD_EEFF, 4'd15);
		send_byte(8'h5A, 1'b1);

		// Deleted match on the last byte: no beat carries the string end
		drain();
		load_rewrite_rule(64'h6261, 4'd2, 64'h1234, 4'd0);
		send_byte(8'h78, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);

		// Oversized pattern length saturates, full-width match then a flush
		drain();
		load_rewrite_rule(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0, 4'd9);
		repeat (8) send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// Overlapping candidates: scanning resumes after the hit
		drain();
		load_rewrite_rule(64'h6161, 4'd2, 64'h58, 4'd1);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b1);

		// Pattern rewritten mid-string drops the held bytes
		drain();
		load_rewrite_rule(64'h636261, 4'd3, 64'h2A, 4'd1);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		drain();
		write_reg(REG_PATTERN_BYTES, 64'h7A7A7A);
		send_byte(8'h63, 1'b0);
		drain();
		write_reg(REG_PATTERN_LENGTH, 64'd1);
		send_byte(8'h7A, 1'b1);

		// Substitute rewritten mid-string applies from the next emission
		drain();
		load_rewrite_rule(64'h71, 4'd1, 64'h31, 4'd1);
		send_byte(8'h71, 1'b0);
		drain();
		write_reg(REG_SUBSTITUTE_BYTES, 64'h3332);
		write_reg(REG_SUBSTITUTE_LENGTH, 64'd2);
		send_byte(8'h71, 1'b1);

		// Random phases; the last two run without idling
		for (int k = 0; k < PHASES; k++) begin
			sender_idles = (k < PHASES - 2);
			receiver_idles = (k < PHASES - 2);
			if (k % 2) begin
				for (int i = 0; i < 8; i++)
					pat[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
			end else begin
				pat = {$urandom(), $urandom()};
			end
			run_phase(PHASE_BYTES, pat, PAT_LENGTHS[k], {$urandom(), $urandom()},
				(k == 3) ? 4'd0 : (k == 5) ? 4'd8 : 4'($urandom_range(0, 15)));
		end

		drain();
		$display("Sent %0d source bytes in %0d strings under %0d rewrite rules.",
			bytes_sent, tracker.strings_seen, settings_used);
		$display("Checked %0d rewritten bytes, %0d pattern hits, insert and delete modes.",
			tracker.beats_checked, tracker.hits);
		if (tracker.errors == 0)
			$display("tb_stream_find_replace: clean");
		else
			$display("tb_stream_find_replace: errors");
		$finish;
	end
endmodule
